// ===== sv/pmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsc_pkg: shared types and constants of the PID motor speed controller
// Field widths, fixed-point scale factors, register indexes and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package pmsc_pkg;

    localparam int COUNT_W    = 32;   // encoder_count
    localparam int TIME_W     = 32;   // time_ms
    localparam int GAIN_W     = 16;   // gains, signed Q8.x
    localparam int TARGET_W   = 21;   // target_speed, signed integer
    localparam int CFG_W      = 21;   // widest register
    localparam int CFG_IDX_W  = 2;
    localparam int Q_W        = 32;   // speed, error, derivative: Q24.8
    localparam int INTEG_W    = 48;   // error integral: Q40.8
    localparam int INTQ_W     = 56;   // signed integral increment
    localparam int DRIVE_W    = 9;
    localparam int PWM_W      = 8;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 32;
    localparam int ACC_W      = 64;   // PID sum

    localparam int SPD_NUM_W  = 50;   // |delta| * 256000
    localparam int DNUM_W     = 43;   // |error - prev_error| * 1000
    localparam int SPEED_SCALE = 256000;
    localparam int MS_PER_S    = 1000;

    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_BITS_PER_CYCLE = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2,
        REG_TARGET = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_SPD = 2'd0,
        DIV_INT = 2'd1,
        DIV_DER = 2'd2
    } div_sel_t;

    typedef enum logic [1:0] {
        MUL_P  = 2'd0,
        MUL_D  = 2'd1,
        MUL_IL = 2'd2,
        MUL_IH = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     check;
        logic     div_start;
        div_sel_t div_sel;
        logic     lat_spd;
        logic     calc_err;
        logic     calc_prod;
        logic     calc_dnum;
        logic     lat_int;
        logic     acc_int;
        logic     lat_der;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clr;
        logic     acc_en;
        logic     round;
        logic     commit;
    } pmsc_cmd_t;

    typedef struct packed {
        logic dt_short;
        logic div_done;
    } pmsc_stat_t;

endpackage

// ===== sv/pmsc_divider.sv =====
// ----------------------------------------------------------------------------
// pmsc_divider: shared unsigned restoring divider
// 64-bit dividend by 32-bit divisor, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pmsc_divider
    import pmsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    localparam int STEPS = DIV_NUM_W / DIV_BITS_PER_CYCLE;
    localparam int CNT_W = $clog2(STEPS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;   // dividend shifts out, quotient shifts in
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_NUM_W-1:0] num_next;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_DEN_W:0]   trial;

    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial    = {rem_next, num_next[DIV_NUM_W-1]};
            num_next = {num_next[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial       = trial - {1'b0, den_reg};
                num_next[0] = 1'b1;
            end
            rem_next = trial[DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

endmodule

// ===== sv/pmsc_datapath.sv =====
// ----------------------------------------------------------------------------
// pmsc_datapath: PID datapath
// Config and loop state, speed/error/integral/derivative arithmetic, the
// multiply-accumulate of the PID sum and the output register.
// ----------------------------------------------------------------------------
module pmsc_datapath
    import pmsc_pkg::*;
#(
    parameter int DRIVE_MAX      = 255,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [S_TDATA_W-1:0] in_data,
    input  pmsc_cmd_t            cmd,
    output pmsc_stat_t           st,
    output logic [M_TDATA_W-1:0] out_data
);

    localparam int SHIFT = 8 + GAIN_FRAC_BITS;
    localparam int QW    = ACC_W - SHIFT;
    localparam int DRV_W = $clog2(DRIVE_MAX + 1) + 1;
    localparam int DX_W  = (DRV_W > DRIVE_W) ? DRV_W : DRIVE_W;
    localparam logic signed [QW-1:0]    Q_DMAX = QW'(DRIVE_MAX);
    localparam logic signed [DRV_W-1:0] D_DMAX = DRV_W'(DRIVE_MAX);
    localparam logic signed [ACC_W-1:0] BIAS   = (ACC_W'(1) << SHIFT) - ACC_W'(1);

    // saturate a quotient magnitude with sign to signed 32 bits
    function automatic logic signed [Q_W-1:0] sat_q(input logic [DIV_NUM_W-1:0] mag,
                                                    input logic neg);
        logic [DIV_NUM_W-1:0] lim;
        logic [DIV_NUM_W-1:0] m;
        lim = neg ? DIV_NUM_W'(64'h8000_0000) : DIV_NUM_W'(64'h7FFF_FFFF);
        m   = (mag > lim) ? lim : mag;
        return neg ? -$signed(m[Q_W-1:0]) : $signed(m[Q_W-1:0]);
    endfunction

    // configuration and loop state
    logic signed [GAIN_W-1:0]   gain_p_reg;
    logic signed [GAIN_W-1:0]   gain_i_reg;
    logic signed [GAIN_W-1:0]   gain_d_reg;
    logic signed [TARGET_W-1:0] target_reg;
    logic [COUNT_W-1:0]         prev_count_reg;
    logic [TIME_W-1:0]          prev_time_reg;
    logic signed [Q_W-1:0]      prev_error_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [INTEG_W-1:0]  integ_next;

    // per-sample working registers
    logic [COUNT_W-1:0]        count_reg;
    logic [TIME_W-1:0]         time_reg;
    logic [TIME_W-1:0]         dt_reg;
    logic [SPD_NUM_W-1:0]      spd_num_reg;
    logic                      spd_neg_reg;
    logic signed [Q_W-1:0]     speed_reg;
    logic signed [Q_W-1:0]     error_reg;
    logic [DIV_NUM_W-1:0]      prod_mag_reg;
    logic                      prod_neg_reg;
    logic signed [Q_W:0]       ediff_reg;
    logic [DNUM_W-1:0]         dnum_reg;
    logic                      dnum_neg_reg;
    logic signed [INTQ_W-1:0]  intq_reg;
    logic signed [Q_W-1:0]     deriv_reg;
    logic signed [ACC_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DRV_W-1:0]   drive_reg;
    logic [DRIVE_W-1:0]        out_drive_reg;
    logic [PWM_W-1:0]          out_fwd_reg;
    logic [PWM_W-1:0]          out_rev_reg;

    // combinational terms
    logic [COUNT_W-1:0]        delta;
    logic [COUNT_W-1:0]        delta_mag;
    logic signed [Q_W+1:0]     err_wide;
    logic signed [Q_W-1:0]     err_sat;
    logic [Q_W-1:0]            err_mag;
    logic [Q_W:0]              ediff_mag;
    logic signed [INTEG_W+8:0] integ_sum;
    logic signed [47:0]        mul_p;
    logic signed [47:0]        mul_d;
    logic signed [40:0]        mul_il;
    logic signed [39:0]        mul_ih;
    logic signed [ACC_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]   biased;
    logic signed [QW-1:0]      q_drive;
    logic signed [DRV_W-1:0]   drive_next;
    logic signed [DX_W-1:0]    dx;
    logic signed [DX_W-1:0]    ndx;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_DEN_W-1:0]      div_den;
    logic                      div_done;
    logic [DIV_NUM_W-1:0]      div_quot;

    // speed numerator
    assign delta     = count_reg - prev_count_reg;
    assign delta_mag = delta[COUNT_W-1] ? -delta : delta;

    // error = target * 256 - speed, saturated
    assign err_wide = $signed({{5{target_reg[TARGET_W-1]}}, target_reg, 8'b0})
                    - $signed({{2{speed_reg[Q_W-1]}}, speed_reg});
    always_comb
    begin
        if (err_wide[Q_W+1:Q_W-1] == 3'b000 || err_wide[Q_W+1:Q_W-1] == 3'b111)
            err_sat = err_wide[Q_W-1:0];
        else if (err_wide[Q_W+1])
            err_sat = {1'b1, {(Q_W-1){1'b0}}};
        else
            err_sat = {1'b0, {(Q_W-1){1'b1}}};
    end

    assign err_mag   = error_reg[Q_W-1] ? -error_reg : error_reg;
    assign ediff_mag = ediff_reg[Q_W] ? -ediff_reg : ediff_reg;

    // integral update, saturated to 48 bits
    assign integ_sum = $signed({{9{integ_reg[INTEG_W-1]}}, integ_reg})
                     + $signed({intq_reg[INTQ_W-1], intq_reg});
    always_comb
    begin
        if (integ_sum[INTEG_W+8:INTEG_W-1] == '0 || integ_sum[INTEG_W+8:INTEG_W-1] == '1)
            integ_next = integ_sum[INTEG_W-1:0];
        else if (integ_sum[INTEG_W+8])
            integ_next = {1'b1, {(INTEG_W-1){1'b0}}};
        else
            integ_next = {1'b0, {(INTEG_W-1){1'b1}}};
    end

    // PID products; the 48-bit integral goes through in two halves
    assign mul_p  = gain_p_reg * error_reg;
    assign mul_d  = gain_d_reg * deriv_reg;
    assign mul_il = gain_i_reg * $signed({1'b0, integ_reg[23:0]});
    assign mul_ih = gain_i_reg * $signed(integ_reg[INTEG_W-1:24]);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_P:   prod_next = ACC_W'(mul_p);
            MUL_D:   prod_next = ACC_W'(mul_d);
            MUL_IL:  prod_next = ACC_W'(mul_il);
            MUL_IH:  prod_next = ACC_W'(mul_ih) <<< 24;
            default: prod_next = '0;
        endcase
    end

    // truncate toward zero, then saturate to +-DRIVE_MAX
    assign biased  = acc_reg + (acc_reg[ACC_W-1] ? BIAS : '0);
    assign q_drive = $signed(biased[ACC_W-1:SHIFT]);
    always_comb
    begin
        if (q_drive > Q_DMAX)
            drive_next = D_DMAX;
        else if (q_drive < -Q_DMAX)
            drive_next = -D_DMAX;
        else
            drive_next = q_drive[DRV_W-1:0];
    end

    assign dx  = DX_W'(drive_reg);
    assign ndx = -dx;

    // divider operands
    always_comb
    begin
        case (cmd.div_sel)
            DIV_SPD:
            begin
                div_num = DIV_NUM_W'(spd_num_reg);
                div_den = dt_reg;
            end
            DIV_INT:
            begin
                div_num = prod_mag_reg;
                div_den = DIV_DEN_W'(MS_PER_S);
            end
            default:
            begin
                div_num = DIV_NUM_W'(dnum_reg);
                div_den = dt_reg;
            end
        endcase
    end

    pmsc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // config registers and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            target_reg     <= '0;
            integ_reg      <= '0;
            prev_count_reg <= '0;
            prev_time_reg  <= '0;
            prev_error_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GAIN_P:
                    begin
                        gain_p_reg <= cfg_data[GAIN_W-1:0];
                        integ_reg  <= '0;
                    end
                    REG_GAIN_I:
                    begin
                        gain_i_reg <= cfg_data[GAIN_W-1:0];
                        integ_reg  <= '0;
                    end
                    REG_GAIN_D:
                    begin
                        gain_d_reg <= cfg_data[GAIN_W-1:0];
                        integ_reg  <= '0;
                    end
                    REG_TARGET:
                        target_reg <= cfg_data[TARGET_W-1:0];
                    default: ;
                endcase
            end
            else if (cmd.acc_int)
            begin
                integ_reg <= integ_next;
            end
            if (cmd.commit)
            begin
                prev_count_reg <= count_reg;
                prev_time_reg  <= time_reg;
                prev_error_reg <= error_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            count_reg <= in_data[COUNT_W-1:0];
            time_reg  <= in_data[S_TDATA_W-1:COUNT_W];
            dt_reg    <= in_data[S_TDATA_W-1:COUNT_W] - prev_time_reg;
        end
        if (cmd.check)
        begin
            spd_num_reg <= SPD_NUM_W'(delta_mag) * SPD_NUM_W'(SPEED_SCALE);
            spd_neg_reg <= delta[COUNT_W-1];
        end
        if (cmd.lat_spd && div_done)
            speed_reg <= sat_q(div_quot, spd_neg_reg);
        if (cmd.calc_err)
            error_reg <= err_sat;
        if (cmd.calc_prod)
        begin
            prod_mag_reg <= DIV_NUM_W'(err_mag) * DIV_NUM_W'(dt_reg);
            prod_neg_reg <= error_reg[Q_W-1];
            ediff_reg    <= $signed({error_reg[Q_W-1], error_reg})
                          - $signed({prev_error_reg[Q_W-1], prev_error_reg});
        end
        if (cmd.calc_dnum)
        begin
            dnum_reg     <= DNUM_W'(ediff_mag) * DNUM_W'(MS_PER_S);
            dnum_neg_reg <= ediff_reg[Q_W];
        end
        if (cmd.lat_int && div_done)
            intq_reg <= prod_neg_reg ? -$signed(div_quot[INTQ_W-1:0])
                                     : $signed(div_quot[INTQ_W-1:0]);
        if (cmd.lat_der && div_done)
            deriv_reg <= sat_q(div_quot, dnum_neg_reg);
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_en)
            acc_reg <= acc_reg + prod_reg;
        if (cmd.round)
            drive_reg <= drive_next;
        if (cmd.commit)
        begin
            out_drive_reg <= dx[DRIVE_W-1:0];
            out_fwd_reg   <= (dx > 0) ? dx[PWM_W-1:0] : '0;
            out_rev_reg   <= (dx < 0) ? ndx[PWM_W-1:0] : '0;
        end
    end

    assign st.dt_short = (dt_reg[TIME_W-1:1] == '0);
    assign st.div_done = div_done;
    assign out_data    = {{(M_TDATA_W - DRIVE_W - 2*PWM_W){1'b0}},
                          out_rev_reg, out_fwd_reg, out_drive_reg};

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (drive_reg <= D_DMAX && drive_reg >= -D_DMAX))
        else $error("drive outside saturation limits");

    a_pwm_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_fwd_reg == '0 || out_rev_reg == '0))
        else $error("forward and reverse duty both active");

endmodule

// ===== sv/pmsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmsc_ctrl: sequencer of the PID controller
// Steps the datapath through one sample and owns the stream handshakes.
// ----------------------------------------------------------------------------
module pmsc_ctrl
    import pmsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  pmsc_stat_t st,
    output pmsc_cmd_t  cmd
);

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_CHECK    = 18'h00002,
        S_SPD_GO   = 18'h00004,
        S_SPD_WAIT = 18'h00008,
        S_ERR      = 18'h00010,
        S_PROD     = 18'h00020,
        S_INT_GO   = 18'h00040,
        S_INT_WAIT = 18'h00080,
        S_INT_ACC  = 18'h00100,
        S_DER_GO   = 18'h00200,
        S_DER_WAIT = 18'h00400,
        S_MUL_P    = 18'h00800,
        S_MUL_D    = 18'h01000,
        S_MUL_IL   = 18'h02000,
        S_MUL_IH   = 18'h04000,
        S_ACC      = 18'h08000,
        S_ROUND    = 18'h10000,
        S_OUT      = 18'h20000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = st.dt_short ? S_IDLE : S_SPD_GO;
            end
            S_SPD_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SPD;
                state_next    = S_SPD_WAIT;
            end
            S_SPD_WAIT:
            begin
                cmd.lat_spd = 1'b1;
                if (st.div_done)
                    state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = S_PROD;
            end
            S_PROD:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = S_INT_GO;
            end
            S_INT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_INT;
                cmd.calc_dnum = 1'b1;
                state_next    = S_INT_WAIT;
            end
            S_INT_WAIT:
            begin
                cmd.lat_int = 1'b1;
                if (st.div_done)
                    state_next = S_INT_ACC;
            end
            S_INT_ACC:
            begin
                cmd.acc_int = 1'b1;
                state_next  = S_DER_GO;
            end
            S_DER_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DER;
                state_next    = S_DER_WAIT;
            end
            S_DER_WAIT:
            begin
                cmd.div_sel = DIV_DER;
                cmd.lat_der = 1'b1;
                if (st.div_done)
                    state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                cmd.acc_clr = 1'b1;
                state_next  = S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                cmd.acc_en  = 1'b1;
                state_next  = S_MUL_IL;
            end
            S_MUL_IL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_IL;
                cmd.acc_en  = 1'b1;
                state_next  = S_MUL_IH;
            end
            S_MUL_IH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_IH;
                cmd.acc_en  = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

endmodule

// ===== sv/pid_motor_speed_controller_unit.sv =====
// ----------------------------------------------------------------------------
// pid_motor_speed_controller_unit: PID motor speed controller
// Encoder samples in, saturated drive and sign-magnitude PWM duties out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per control sample, tdata = encoder_count (bits
//   31:0) and time_ms (bits 63:32). Master stream: one beat per used sample,
//   tdata = drive, pwm_forward, pwm_reverse from bit 0 up.
//   Config port: cfg_we/cfg_index/cfg_data write gain_p, gain_i, gain_d and
//   target_speed (index 0..3); any gain write clears the integral.
//   Write only while no sample is in flight.
//   Timing: samples are processed one at a time. A sample whose elapsed
//   time is 1 ms or less is dropped with no output beat. Otherwise a sample
//   makes three passes through the shared 2-bit-per-cycle divider (for
//   speed, integral step and derivative), then runs the sequenced
//   multiply-accumulate and rounding steps. tready returns as soon as the
//   result is in the output register.
//   Stall: a result waits in the output register while m_axis_tready is low;
//   the next sample is still taken and computed, and only its final write
//   waits until the pending beat has gone.
//   Reset: gains, target, previous sample and integral all clear to zero;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_motor_speed_controller_unit
    import pmsc_pkg::*;
#(
    parameter int DRIVE_MAX      = 255,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // sample stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // encoder_count[31:0], time_ms[63:32]
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // drive[8:0], pwm_forward[16:9],
                                                 // pwm_reverse[24:17], zero[31:25]
);

    pmsc_cmd_t  cmd;
    pmsc_stat_t st;

    // sequencer: one state per datapath step
    pmsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    // arithmetic, loop state and output register
    pmsc_datapath #(
        .DRIVE_MAX      (DRIVE_MAX),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .st        (st),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== bench/pid_motor_speed_controller_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_motor_speed_controller_unit_test: self-checking bench for the PID unit
// Streams encoder/timestamp samples into the block under random idling and
// backpressure, predicts every drive beat from a local fixed-point model and
// compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module pid_motor_speed_controller_unit_test;

    import pmsc_pkg::*;

    localparam int          PERIOD       = 20;
    localparam int          RESET_CYCLES = 6;
    localparam int          DRAIN_CYCLES = 240;
    localparam int          HOLD_CYCLES  = 800;       // long receiver hold-off
    localparam int          RAND_PHASES  = 12;
    localparam int          PHASE_ITEMS  = 155;       // used samples per random phase
    localparam int unsigned LIMIT_CYCLES = 3_000_000;

    // fixed-point scale factors and saturation bounds
    localparam longint SPEED_PER_MS = 256000;          // ticks/ms to Q24.8 ticks/s
    localparam longint MS_IN_S      = 1000;
    localparam longint SUM_ONE      = longint'(1) << 16; // PID sum is Q.16
    localparam longint DRIVE_LIM    = 255;
    localparam longint Q_MAX        = (longint'(1) << 31) - 1;
    localparam longint Q_MIN        = -(longint'(1) << 31);
    localparam longint I_MAX        = (longint'(1) << 47) - 1;
    localparam longint I_MIN        = -(longint'(1) << 47);

    // register setting styles
    localparam int SET_GENTLE  = 0;
    localparam int SET_FULL    = 1;
    localparam int SET_EXTREME = 2;

    typedef struct packed {
        logic [7:0] rev;
        logic [7:0] fwd;
        logic [8:0] drive;
    } duty_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // encoder_count[31:0], time_ms[63:32]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // drive[8:0], pwm_forward[16:9],
                                                // pwm_reverse[24:17], zero[31:25]

    // stimulus and expectation stores
    logic [63:0] sample_q[$];
    duty_t       duty_q[$];

    // local copy of the controller state and registers
    longint      kp, ki, kd, speed_goal;
    logic [31:0] last_count, last_time;
    longint      last_err, err_sum;

    // sample generator bookkeeping (tracks what the block will keep)
    logic [31:0] gen_count, gen_time;
    int          gen_made;

    int          fault_cnt  = 0;
    int          beats_seen = 0;
    int          dropped    = 0;
    int          settings   = 0;
    int unsigned cycle_cnt  = 0;

    logic        in_took       = 1'b0;  // input beat taken at the last rising edge
    logic        steady        = 1'b0;  // no idling on either side
    logic        pressure_go   = 1'b0;
    logic        pressure_done = 1'b0;
    int          send_gap      = 0;
    int          stall_left    = 0;
    int          hold_left     = 0;

    pid_motor_speed_controller_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ------------------------------------------------------------------------
    // Prediction and checking
    // ------------------------------------------------------------------------
    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Short interval (1 ms or less, equal stamps included) leaves the state alone
    // and gives no beat. The count difference wraps modulo 2^32.
    function automatic void predict_drive(input logic [63:0] beat);
        logic [31:0] cnt, tms, dt_raw, diff;
        longint      dt, delta, speed, err, slope, sum, drv, mag;
        duty_t       d;
        cnt    = beat[31:0];
        tms    = beat[63:32];
        dt_raw = tms - last_time;
        if (dt_raw <= 32'd1)
        begin
            dropped++;
            return;
        end
        dt      = {32'd0, dt_raw};
        diff    = cnt - last_count;
        delta   = longint'($signed(diff));
        speed   = clip(delta * SPEED_PER_MS / dt, Q_MIN, Q_MAX);
        err     = clip(speed_goal * 256 - speed, Q_MIN, Q_MAX);
        err_sum = clip(err_sum + (err * dt) / MS_IN_S, I_MIN, I_MAX);
        slope   = clip((err - last_err) * MS_IN_S / dt, Q_MIN, Q_MAX);
        sum     = kp * err + ki * err_sum + kd * slope;
        drv     = clip(sum / SUM_ONE, -DRIVE_LIM, DRIVE_LIM);   // truncates toward zero
        mag     = -drv;
        d.drive = drv[8:0];
        d.fwd   = (drv > 0) ? drv[7:0] : 8'd0;
        d.rev   = (drv < 0) ? mag[7:0] : 8'd0;
        duty_q.push_back(d);
        last_count = cnt;
        last_time  = tms;
        last_err   = err;
    endfunction

    function automatic void note_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= 10)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    function automatic void check_beat(input logic [31:0] beat);
        duty_t want, got;
        got = beat[24:0];
        beats_seen++;
        if (duty_q.size() == 0)
        begin
            note_fault($sformatf("result beat %h with nothing expected", beat));
            return;
        end
        want = duty_q.pop_front();
        if (got.drive !== want.drive || got.fwd !== want.fwd || got.rev !== want.rev
            || beat[31:25] !== 7'd0)
            note_fault($sformatf("drive/fwd/rev exp %0d/%0d/%0d got %0d/%0d/%0d pad %h",
                                 $signed(want.drive), want.fwd, want.rev,
                                 $signed(got.drive), got.fwd, got.rev, beat[31:25]));
    endfunction

    // Outputs are sampled here, before the block's own updates of this edge land.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_took <= 1'b0;
        else
        begin
            in_took <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                predict_drive(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_beat(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Sample driver and result receiver, both moving on the falling edge
    // ------------------------------------------------------------------------
    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else if (!s_axis_tvalid || in_took)
        begin
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (sample_q.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= sample_q.pop_front();
                send_gap      <= steady ? 0 : idle_len();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // The one long hold-off lets the block take a sample, finish it, take the
    // next and then stall its input while the driver keeps offering.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
            pressure_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (pressure_go && !pressure_done)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            pressure_done <= 1'b1;
        end
        else if (steady)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // One register write per call; the caller starts on a falling edge and
    // drops cfg_we after the last write of a batch.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GAIN_P:
            begin
                kp      = longint'($signed(val[15:0]));
                err_sum = 0;
            end
            REG_GAIN_I:
            begin
                ki      = longint'($signed(val[15:0]));
                err_sum = 0;
            end
            REG_GAIN_D:
            begin
                kd      = longint'($signed(val[15:0]));
                err_sum = 0;
            end
            REG_TARGET:
                speed_goal = longint'($signed(val));
        endcase
        @(negedge clk);
    endtask

    task automatic offer(input logic [31:0] cnt, input logic [31:0] tms);
        sample_q.push_back({tms, cnt});
        if (tms - gen_time > 32'd1)
        begin
            gen_count = cnt;
            gen_time  = tms;
            gen_made++;
        end
    endtask

    // Mostly plausible motion with small steps; some noise, wild counts and
    // huge or wrapping time jumps.
    task automatic random_sample(input int span);
        logic [31:0] inc, cnt;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 6)
            inc = $urandom_range(0, 1);
        else if (r < 10)
            inc = $urandom;
        else
            inc = $urandom_range(2, 40);
        r = $urandom_range(0, 99);
        if (r < 85)
            cnt = gen_count + ($urandom_range(0, 2 * span) - span);
        else if (r < 95)
            cnt = gen_count + $urandom;
        else
            cnt = $urandom;
        offer(cnt, gen_time + inc);
    endtask

    task automatic load_setting(input int style, input bit every);
        logic [CFG_W-1:0] v;
        int               pick;
        for (int i = 0; i < 4; i++)
        begin
            if (every || $urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 2);
                v    = $urandom;                        // junk above bit 15 for gains
                case (style)
                    SET_GENTLE:
                        if (i == REG_TARGET)
                            v = $urandom_range(0, 6000) - 3000;
                        else
                            v[15:0] = $urandom_range(0, 16) - 8;
                    SET_EXTREME:
                        if (i == REG_TARGET)
                            v = (pick == 0) ? 21'h100000 : ((pick == 1) ? 21'h0FFFFF : '0);
                        else
                            v[15:0] = (pick == 0) ? 16'h8000
                                                  : ((pick == 1) ? 16'h7FFF : 16'h0000);
                    default:
                        ;
                endcase
                write_reg(cfg_reg_t'(i), v);
            end
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Block idle: everything sent, every beat back, plus room for a dropped
    // sample still being discarded.
    task automatic settle();
        while (sample_q.size() != 0 || s_axis_tvalid || duty_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int goal;
        kp         = 0;
        ki         = 0;
        kd         = 0;
        speed_goal = 0;
        last_count = '0;
        last_time  = '0;
        last_err   = 0;
        err_sum    = 0;
        gen_count  = '0;
        gen_time   = '0;
        gen_made   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: unit-ish gains, modest target
        write_reg(REG_GAIN_P, 21'd256);
        write_reg(REG_GAIN_I, 21'd64);
        write_reg(REG_GAIN_D, 21'd16);
        write_reg(REG_TARGET, 21'd1000);
        cfg_we <= 1'b0;
        settings++;
        offer(32'd0, 32'd0);                    // equal stamp to reset value: dropped
        offer(32'd5, 32'd1);                    // 1 ms: dropped
        offer(32'd10, 32'd2);                   // shortest kept interval
        offer(32'h8000_0009, 32'd4);            // biggest forward step, speed saturates
        offer(32'h0000_0009, 32'd6);            // biggest backward step
        offer(32'h7FFF_FFFF, 32'hFFFF_FFF0);    // huge interval
        offer(32'h8000_0001, 32'd5);            // time wraps, count crosses sign
        offer(32'h8000_0001, 32'd5);            // repeated stamp: dropped
        offer(32'hFFFF_FFFF, 32'd4);            // longest possible interval
        for (int k = 1; k <= 4; k++)
            offer(32'hFFFF_FFFF + 10 * k, 32'd4 + 10 * k);   // on target, count wraps
        settle();

        // directed: gain and target extremes, then all gains zero
        write_reg(REG_GAIN_P, 21'h007FFF);
        write_reg(REG_GAIN_I, 21'h1F8000);
        write_reg(REG_GAIN_D, 21'h007FFF);
        write_reg(REG_TARGET, 21'h100000);
        cfg_we <= 1'b0;
        settings++;
        for (int k = 0; k < 3; k++)
            offer(gen_count + 32'd7, gen_time + 32'd3);
        settle();
        write_reg(REG_GAIN_P, 21'h008000);
        write_reg(REG_GAIN_I, 21'h007FFF);
        write_reg(REG_GAIN_D, 21'h008000);
        write_reg(REG_TARGET, 21'h0FFFFF);
        cfg_we <= 1'b0;
        settings++;
        for (int k = 0; k < 3; k++)
            offer(gen_count - 32'd5, gen_time + 32'd2);
        settle();
        write_reg(REG_GAIN_P, 21'd0);
        write_reg(REG_GAIN_I, 21'd0);
        write_reg(REG_GAIN_D, 21'd0);
        write_reg(REG_TARGET, 21'd0);
        cfg_we <= 1'b0;
        settings++;
        offer(gen_count + 32'd3, gen_time + 32'd9);
        offer(gen_count - 32'd3, gen_time + 32'd9);
        settle();

        // random phases; phase 1 runs without idling and carries the long hold-off
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            steady <= (p % 4 == 1);
            if (p == 1)
                pressure_go <= 1'b1;
            load_setting(p % 3, p == 0);
            goal = gen_made + PHASE_ITEMS;
            while (gen_made < goal)
                random_sample((p % 3 == SET_GENTLE) ? 16
                              : ((p % 3 == SET_FULL) ? 4096 : 64));
            settle();
        end

        $display("checked %0d drive beats over %0d register settings", beats_seen, settings);
        $display("%0d short-interval samples were dropped, %0d mismatches", dropped,
                 fault_cnt);
        if (fault_cnt == 0)
            $display("pid_motor_speed_controller_unit_test: done, clean");
        else
            $display("pid_motor_speed_controller_unit_test: done, errors");
        $finish;
    end

    // watchdog
    initial
    begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("pid_motor_speed_controller_unit_test: done, errors");
        $finish;
    end

endmodule
